/* hw/rtl/queued_spin_lock_manager_defines.svh */
// assertion macros for the queued spin lock manager checker
`ifndef QUEUED_SPIN_LOCK_MANAGER_DEFINES_SVH
`define QUEUED_SPIN_LOCK_MANAGER_DEFINES_SVH

// same-cycle implication, off during reset
`define QSLM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qslm check failed");

// next-cycle implication, off during reset
`define QSLM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qslm check failed");

// next-cycle implication that also covers reset
`define QSLM_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("qslm check failed");

`endif

/* hw/rtl/qslm_pkg.sv */
// shared types and codes of the queued spin lock manager
package qslm_pkg;

   localparam int QSLM_NUM_CPUS = 16;
   localparam int ROLE_W = 2;

   // request codes
   localparam logic [1:0] REQ_LOCK   = 2'd0;
   localparam logic [1:0] REQ_CANCEL = 2'd1;
   localparam logic [1:0] REQ_UNLOCK = 2'd2;
   localparam logic [1:0] REQ_BAD    = 2'd3;

   // per-processor role
   localparam logic [ROLE_W-1:0] ROLE_IDLE = 2'd0;
   localparam logic [ROLE_W-1:0] ROLE_WAIT = 2'd1;
   localparam logic [ROLE_W-1:0] ROLE_OWN  = 2'd2;

   // response status
   localparam logic [2:0] ST_GRANTED   = 3'd0;
   localparam logic [2:0] ST_QUEUED    = 3'd1;
   localparam logic [2:0] ST_CANCELLED = 3'd2;
   localparam logic [2:0] ST_TOO_LATE  = 3'd3;
   localparam logic [2:0] ST_FREED     = 3'd4;
   localparam logic [2:0] ST_HANDOFF   = 3'd5;
   localparam logic [2:0] ST_ERROR     = 3'd6;

   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] cpu_id;
   } qslm_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       handoff_valid;
      logic [3:0] handoff_cpu;
   } qslm_rsp_type;

   typedef struct packed {
      logic next_we;
      logic prev_we;
      logic role_we;
   } qslm_wen_type;

endpackage

/* hw/rtl/qslm_ram.sv */
// generic single-write, single-read ram with registered read data
module qslm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/qslm_seq.sv */
// request sequencer: evaluates one transaction against the link tables and writes them back
module qslm_seq #(
   parameter int NUM_CPUS = qslm_pkg::QSLM_NUM_CPUS
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_valid,
   output logic                                           req_stall,
   input  qslm_pkg::qslm_req_type                         req_data,
   output logic                                           rsp_valid,
   input  logic                                           rsp_stall,
   output qslm_pkg::qslm_rsp_type                         rsp_data,
   output logic [((NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1)-1:0] rd_addr,
   output qslm_pkg::qslm_wen_type                         wen,
   output logic [((NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1)-1:0] next_wr_addr,
   output logic [$clog2(NUM_CPUS + 1)-1:0]                next_wr_data,
   output logic [((NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1)-1:0] prev_wr_addr,
   output logic [$clog2(NUM_CPUS + 1)-1:0]                prev_wr_data,
   output logic [((NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1)-1:0] role_wr_addr,
   output logic [qslm_pkg::ROLE_W-1:0]                    role_wr_data,
   input  logic [$clog2(NUM_CPUS + 1)-1:0]                next_rd_data,
   input  logic [$clog2(NUM_CPUS + 1)-1:0]                prev_rd_data,
   input  logic [qslm_pkg::ROLE_W-1:0]                    role_rd_data
);

   import qslm_pkg::*;

   localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int SLOT_W = $clog2(NUM_CPUS + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_WR2  = 2'd2;

   function automatic logic slot_ok(input logic [SLOT_W-1:0] s);
      slot_ok = (s != '0) && (32'(s) <= NUM_CPUS);
   endfunction

   function automatic logic [CPU_W-1:0] slot_idx(input logic [SLOT_W-1:0] s);
      slot_idx = CPU_W'(s - SLOT_W'(1));
   endfunction

   logic [1:0]          state_ff, state_in;
   qslm_req_type        req_ff, req_in;
   logic [NUM_CPUS-1:0] valid_ff, valid_in;
   logic [SLOT_W-1:0]   tail_ff, tail_in;
   logic                pend_ff, pend_in;
   qslm_rsp_type        res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   qslm_rsp_type        rsp_data_ff, rsp_data_in;
   qslm_wen_type        w2_wen_ff, w2_wen_in;
   logic [CPU_W-1:0]    w2_next_addr_ff, w2_next_addr_in;
   logic [SLOT_W-1:0]   w2_next_data_ff, w2_next_data_in;
   logic [CPU_W-1:0]    w2_prev_addr_ff, w2_prev_addr_in;
   logic [SLOT_W-1:0]   w2_prev_data_ff, w2_prev_data_in;

   logic               eval;
   logic               accept;
   logic               out_free;
   logic               cpu_oob;
   logic [CPU_W-1:0]   cpu_idx;
   logic [SLOT_W-1:0]  self_slot;
   logic               vld;
   logic [ROLE_W-1:0]  r_role;
   logic [SLOT_W-1:0]  r_next, r_prev, p_slot, n_slot;
   qslm_rsp_type       res;
   logic               self_wr;
   logic [SLOT_W-1:0]  s_prev;
   logic [ROLE_W-1:0]  s_role;

   assign eval      = (state_ff == S_EVAL);
   assign req_stall = (state_ff != S_IDLE) || pend_ff;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign cpu_idx   = CPU_W'(req_ff.cpu_id);
   assign cpu_oob   = 32'(req_ff.cpu_id) >= NUM_CPUS;
   assign self_slot = SLOT_W'(cpu_idx) + SLOT_W'(1);

   // entries never written read as their reset value
   assign vld    = valid_ff[cpu_idx];
   assign r_role = vld ? role_rd_data : ROLE_IDLE;
   assign r_next = vld ? next_rd_data : '0;
   assign r_prev = vld ? prev_rd_data : '0;
   assign p_slot = slot_ok(r_prev) ? r_prev : '0;
   assign n_slot = slot_ok(r_next) ? r_next : '0;

   // decision for the transaction under evaluation
   always_comb begin
      res             = '{status: ST_ERROR, handoff_valid: 1'b0, handoff_cpu: 4'd0};
      self_wr         = 1'b0;
      s_prev          = '0;
      s_role          = ROLE_IDLE;
      tail_in         = tail_ff;
      w2_wen_in       = '0;
      w2_next_addr_in = '0;
      w2_next_data_in = '0;
      w2_prev_addr_in = '0;
      w2_prev_data_in = '0;
      if (!cpu_oob) begin
         case (req_ff.req_type)
            REQ_LOCK: begin
               if (r_role == ROLE_IDLE) begin
                  self_wr = 1'b1;
                  tail_in = self_slot;
                  if (!slot_ok(tail_ff)) begin
                     s_role     = ROLE_OWN;
                     res.status = ST_GRANTED;
                  end else begin
                     s_prev            = tail_ff;
                     s_role            = ROLE_WAIT;
                     w2_wen_in.next_we = 1'b1;
                     w2_next_addr_in   = slot_idx(tail_ff);
                     w2_next_data_in   = self_slot;
                     res.status        = ST_QUEUED;
                  end
               end
            end
            REQ_CANCEL: begin
               if (r_role == ROLE_OWN) begin
                  res.status = ST_TOO_LATE;
               end else if (r_role == ROLE_WAIT) begin
                  self_wr    = 1'b1;
                  res.status = ST_CANCELLED;
                  if (n_slot == '0) begin
                     if (tail_ff == self_slot) begin
                        tail_in = p_slot;
                     end
                  end else begin
                     w2_wen_in.prev_we = 1'b1;
                     w2_prev_addr_in   = slot_idx(n_slot);
                     w2_prev_data_in   = p_slot;
                  end
                  // predecessor skips over the leaving waiter
                  if (p_slot != '0) begin
                     w2_wen_in.next_we = 1'b1;
                     w2_next_addr_in   = slot_idx(p_slot);
                     w2_next_data_in   = n_slot;
                  end
               end
            end
            REQ_UNLOCK: begin
               if (r_role == ROLE_OWN) begin
                  self_wr = 1'b1;
                  if (n_slot == '0) begin
                     tail_in    = '0;
                     res.status = ST_FREED;
                  end else begin
                     w2_wen_in.role_we = 1'b1;
                     w2_wen_in.prev_we = 1'b1;
                     w2_prev_addr_in   = slot_idx(n_slot);
                     res.status        = ST_HANDOFF;
                     res.handoff_valid = 1'b1;
                     res.handoff_cpu   = 4'(n_slot - SLOT_W'(1));
                  end
               end
            end
            default: begin
               res.status = ST_ERROR;
            end
         endcase
      end
   end

   // memory ports: own entry in evaluation, neighbor entries in the write-back state
   always_comb begin
      rd_addr = (state_ff == S_IDLE) ? CPU_W'(req_data.cpu_id) : cpu_idx;
      if (eval) begin
         wen.next_we  = self_wr;
         wen.prev_we  = self_wr;
         wen.role_we  = self_wr;
         next_wr_addr = cpu_idx;
         next_wr_data = '0;
         prev_wr_addr = cpu_idx;
         prev_wr_data = s_prev;
         role_wr_addr = cpu_idx;
         role_wr_data = s_role;
      end else begin
         wen.next_we  = (state_ff == S_WR2) && w2_wen_ff.next_we;
         wen.prev_we  = (state_ff == S_WR2) && w2_wen_ff.prev_we;
         wen.role_we  = (state_ff == S_WR2) && w2_wen_ff.role_we;
         next_wr_addr = w2_next_addr_ff;
         next_wr_data = w2_next_data_ff;
         prev_wr_addr = w2_prev_addr_ff;
         prev_wr_data = w2_prev_data_ff;
         role_wr_addr = w2_prev_addr_ff;
         role_wr_data = ROLE_OWN;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      valid_in     = valid_ff;
      pend_in      = pend_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = (w2_wen_in != '0) ? S_WR2 : S_IDLE;
         end
         S_WR2: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (eval && self_wr) begin
         valid_in[cpu_idx] = 1'b1;
      end
      if (eval) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = res;
         end else begin
            pend_in = 1'b1;
            res_in  = res;
         end
      end else if (pend_ff && out_free) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         tail_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         w2_wen_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (eval) begin
            tail_ff   <= tail_in;
            w2_wen_ff <= w2_wen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      if (eval) begin
         w2_next_addr_ff <= w2_next_addr_in;
         w2_next_data_ff <= w2_next_data_in;
         w2_prev_addr_ff <= w2_prev_addr_in;
         w2_prev_data_ff <= w2_prev_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hw/rtl/queued_spin_lock_manager.sv */
// queued spin lock manager: top level with link tables and sequencer
// Usage:
//   req channel: one lock, cancel or unlock transaction per processor request,
//     accepted when req_valid is high and req_stall low.
//   rsp channel: exactly one response per request (status, handoff_valid,
//     handoff_cpu), taken when rsp_valid is high and rsp_stall low.
// The accepted request is registered, evaluated in S_EVAL and its response
//   registered; requests are taken one at a time, plus a write-back state
//   when a neighbor queue entry must also be rewritten (queued lock, cancel
//   of a linked waiter, handoff): each link table has a single write port.
// The next/prev/role tables sit in three synchronous rams read at the
//   requesting processor's entry; one request is in flight at a time.
// Reset clears the tail, the per-entry valid bits (unwritten entries read as
//   idle with no links) and the response register; no clearing pass is needed.
// A stalled response holds; one further response is parked internally, after
//   which req_stall stays high until the receiver takes a response.
module queued_spin_lock_manager #(
   parameter int NUM_CPUS = qslm_pkg::QSLM_NUM_CPUS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  qslm_pkg::qslm_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output qslm_pkg::qslm_rsp_type rsp_data
);

   import qslm_pkg::*;

   localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int SLOT_W = $clog2(NUM_CPUS + 1);

   qslm_wen_type      wen;
   logic [CPU_W-1:0]  rd_addr;
   logic [CPU_W-1:0]  next_wr_addr, prev_wr_addr, role_wr_addr;
   logic [SLOT_W-1:0] next_wr_data, prev_wr_data;
   logic [ROLE_W-1:0] role_wr_data;
   logic [SLOT_W-1:0] next_rd_data, prev_rd_data;
   logic [ROLE_W-1:0] role_rd_data;

   qslm_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_CPUS)) u_next_ram (
      .clock   (clock),
      .wr_en   (wen.next_we),
      .wr_addr (next_wr_addr),
      .wr_data (next_wr_data),
      .rd_addr (rd_addr),
      .rd_data (next_rd_data)
   );

   qslm_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_CPUS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (wen.prev_we),
      .wr_addr (prev_wr_addr),
      .wr_data (prev_wr_data),
      .rd_addr (rd_addr),
      .rd_data (prev_rd_data)
   );

   qslm_ram #(.WIDTH(ROLE_W), .DEPTH(NUM_CPUS)) u_role_ram (
      .clock   (clock),
      .wr_en   (wen.role_we),
      .wr_addr (role_wr_addr),
      .wr_data (role_wr_data),
      .rd_addr (rd_addr),
      .rd_data (role_rd_data)
   );

   qslm_seq #(.NUM_CPUS(NUM_CPUS)) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .rd_addr      (rd_addr),
      .wen          (wen),
      .next_wr_addr (next_wr_addr),
      .next_wr_data (next_wr_data),
      .prev_wr_addr (prev_wr_addr),
      .prev_wr_data (prev_wr_data),
      .role_wr_addr (role_wr_addr),
      .role_wr_data (role_wr_data),
      .next_rd_data (next_rd_data),
      .prev_rd_data (prev_rd_data),
      .role_rd_data (role_rd_data)
   );

endmodule

/* hw/rtl/qslm_checker.sv */
// port-level checks of the queued spin lock manager, bound to the top level
`include "queued_spin_lock_manager_defines.svh"

module qslm_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input qslm_pkg::qslm_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input qslm_pkg::qslm_rsp_type rsp_data
);

   import qslm_pkg::*;

   logic handoff_st;
   logic no_handoff;
   logic bad_req_acc;
   logic rsp_free;
   logic err_rsp;

   assign handoff_st  = (rsp_data.status == ST_HANDOFF);
   assign no_handoff  = rsp_valid && !rsp_data.handoff_valid;
   assign bad_req_acc = req_valid && !req_stall && (req_data.req_type == REQ_BAD);
   assign rsp_free    = !rsp_valid || !rsp_stall;
   assign err_rsp     = rsp_valid && (rsp_data.status == ST_ERROR);

   // a stalled response transaction holds
   `QSLM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // handoff flag goes with the handoff status only
   `QSLM_ASSERT_NOW(a_handoff_flag, rsp_valid, rsp_data.handoff_valid == handoff_st)

   // no handoff target without a handoff
   `QSLM_ASSERT_NOW(a_handoff_cpu_zero, no_handoff, rsp_data.handoff_cpu == 4'd0)

   // an unknown request type answers with an error in the next free cycle
   `QSLM_ASSERT_NEXT(a_bad_req_error, bad_req_acc ##1 rsp_free, err_rsp)

   // reset empties the response register
   `QSLM_ASSERT_NEXT_ALWAYS(a_reset_clears, reset, !rsp_valid)

endmodule

bind queued_spin_lock_manager qslm_checker u_qslm_checker (.*);

/* tb/tb_queued_spin_lock_manager.sv */
// self-checking testbench of the queued spin lock manager: directed and random lock traffic
module tb_queued_spin_lock_manager;
   timeunit 1ns;
   timeprecision 1ps;

   import qslm_pkg::*;

   localparam int NUM_CPUS     = QSLM_NUM_CPUS;
   localparam int RANDOM_ITEMS = 600;
   localparam int QUIET_ITEMS  = 100;
   localparam int CYCLE_LIMIT  = 200000;

   // lock queue predictor and store of expected responses
   class lock_queue_scoreboard;
      logic [4:0]        tail_slot;
      logic [4:0]        next_link[NUM_CPUS];
      logic [4:0]        prev_link[NUM_CPUS];
      logic [ROLE_W-1:0] cpu_role[NUM_CPUS];
      qslm_rsp_type      expected_q[$];
      int                errors;

      function new();
         tail_slot = '0;
         errors    = 0;
         for (int i = 0; i < NUM_CPUS; i++) begin
            next_link[i] = '0;
            prev_link[i] = '0;
            cpu_role[i]  = ROLE_IDLE;
         end
      endfunction

      function bit slot_ok(logic [4:0] s);
         return s >= 5'd1 && int'(s) <= NUM_CPUS;
      endfunction

      function qslm_rsp_type next_response(qslm_req_type r);
         qslm_rsp_type rsp;
         int           c;
         logic [4:0]   self_slot;
         logic [4:0]   p;
         logic [4:0]   n;
         rsp        = '0;
         rsp.status = ST_ERROR;
         c          = int'(r.cpu_id);
         self_slot  = 5'(c + 1);
         if (c >= NUM_CPUS || r.req_type == REQ_BAD) return rsp;
         case (r.req_type)
            REQ_LOCK: begin
               if (cpu_role[c] == ROLE_IDLE) begin
                  next_link[c] = '0;
                  if (!slot_ok(tail_slot)) begin
                     tail_slot    = self_slot;
                     prev_link[c] = '0;
                     cpu_role[c]  = ROLE_OWN;
                     rsp.status   = ST_GRANTED;
                  end else begin
                     prev_link[c] = tail_slot;
                     next_link[int'(tail_slot) - 1] = self_slot;
                     tail_slot    = self_slot;
                     cpu_role[c]  = ROLE_WAIT;
                     rsp.status   = ST_QUEUED;
                  end
               end
            end
            REQ_CANCEL: begin
               if (cpu_role[c] == ROLE_OWN) begin
                  rsp.status = ST_TOO_LATE;
               end else if (cpu_role[c] == ROLE_WAIT) begin
                  p = slot_ok(prev_link[c]) ? prev_link[c] : 5'd0;
                  n = slot_ok(next_link[c]) ? next_link[c] : 5'd0;
                  if (n == 5'd0) begin
                     // last in line: tail falls back to the predecessor
                     if (tail_slot == self_slot) tail_slot = p;
                     if (p != 5'd0) next_link[int'(p) - 1] = '0;
                  end else begin
                     prev_link[int'(n) - 1] = p;
                     if (p != 5'd0) next_link[int'(p) - 1] = n;
                  end
                  prev_link[c] = '0;
                  next_link[c] = '0;
                  cpu_role[c]  = ROLE_IDLE;
                  rsp.status   = ST_CANCELLED;
               end
            end
            REQ_UNLOCK: begin
               if (cpu_role[c] == ROLE_OWN) begin
                  n = slot_ok(next_link[c]) ? next_link[c] : 5'd0;
                  prev_link[c] = '0;
                  next_link[c] = '0;
                  cpu_role[c]  = ROLE_IDLE;
                  if (n == 5'd0) begin
                     tail_slot  = '0;
                     rsp.status = ST_FREED;
                  end else begin
                     cpu_role[int'(n) - 1]  = ROLE_OWN;
                     prev_link[int'(n) - 1] = '0;
                     rsp.status        = ST_HANDOFF;
                     rsp.handoff_valid = 1'b1;
                     rsp.handoff_cpu   = 4'(int'(n) - 1);
                  end
               end
            end
            default: ;
         endcase
         return rsp;
      endfunction

      function void note_request(qslm_req_type r);
         expected_q.push_back(next_response(r));
      endfunction

      function void check_response(qslm_rsp_type got);
         qslm_rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            errors++;
         end
         if (got.handoff_valid !== want.handoff_valid) begin
            $display("%0t: handoff_valid mismatch, expected %0d, actual %0d",
                     $time, want.handoff_valid, got.handoff_valid);
            errors++;
         end
         if (got.handoff_cpu !== want.handoff_cpu) begin
            $display("%0t: handoff_cpu mismatch, expected %0d, actual %0d",
                     $time, want.handoff_cpu, got.handoff_cpu);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // random processor holding the given role, any processor if none does
      function int pick_with_role(logic [ROLE_W-1:0] want);
         int hits[$];
         for (int i = 0; i < NUM_CPUS; i++)
            if (cpu_role[i] == want) hits.push_back(i);
         if (hits.size() == 0) return $urandom_range(NUM_CPUS - 1);
         return hits[$urandom_range(hits.size() - 1)];
      endfunction
   endclass

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   qslm_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   qslm_rsp_type rsp_data;

   lock_queue_scoreboard board = new();

   bit sender_gaps     = 1'b0;
   bit receiver_stalls = 1'b0;
   int stall_left      = 0;
   int cycle_count     = 0;

   queued_spin_lock_manager #(.NUM_CPUS(NUM_CPUS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver: random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (receiver_stalls && $urandom_range(3) == 0) begin
         stall_left <= $urandom_range(3);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
   end

   // present one transaction and hold it until accepted
   task automatic send_request(input logic [1:0] kind, input int cpu);
      qslm_req_type r;
      r.req_type = kind;
      r.cpu_id   = 4'(cpu);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
      if (sender_gaps && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // mostly well-formed traffic: lock by idle cpus, cancel by waiters, unlock by the owner
   task automatic send_random_request();
      int k;
      k = $urandom_range(99);
      if (k < 3)
         send_request(REQ_BAD, $urandom_range(NUM_CPUS - 1));
      else if (k < 52)
         send_request(REQ_LOCK, ($urandom_range(4) != 0) ?
                      board.pick_with_role(ROLE_IDLE) : $urandom_range(NUM_CPUS - 1));
      else if (k < 71)
         send_request(REQ_CANCEL, ($urandom_range(3) != 0) ?
                      board.pick_with_role(ROLE_WAIT) : $urandom_range(NUM_CPUS - 1));
      else
         send_request(REQ_UNLOCK, ($urandom_range(4) != 0) ?
                      board.pick_with_role(ROLE_OWN) : $urandom_range(NUM_CPUS - 1));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset           <= 1'b0;
      sender_gaps     <= 1'b1;
      receiver_stalls <= 1'b1;

      // queue of four, protocol errors, cancels in the middle and at the tail
      send_request(REQ_LOCK, 0);
      send_request(REQ_LOCK, 15);
      send_request(REQ_LOCK, 7);
      send_request(REQ_LOCK, 3);
      send_request(REQ_LOCK, 0);
      send_request(REQ_LOCK, 7);
      send_request(REQ_CANCEL, 0);
      send_request(REQ_CANCEL, 5);
      send_request(REQ_UNLOCK, 15);
      send_request(REQ_UNLOCK, 9);
      send_request(REQ_BAD, 0);
      send_request(REQ_BAD, 15);
      send_request(REQ_CANCEL, 7);
      send_request(REQ_CANCEL, 3);
      // handoffs down the line, then a free lock
      send_request(REQ_LOCK, 3);
      send_request(REQ_UNLOCK, 0);
      send_request(REQ_CANCEL, 15);
      send_request(REQ_UNLOCK, 15);
      send_request(REQ_UNLOCK, 3);
      send_request(REQ_LOCK, 5);
      send_request(REQ_LOCK, 10);
      send_request(REQ_CANCEL, 10);
      send_request(REQ_UNLOCK, 5);
      send_request(REQ_CANCEL, 10);
      send_request(REQ_UNLOCK, 5);
      drain_responses();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) drain_responses();
         if (i >= RANDOM_ITEMS - QUIET_ITEMS) begin
            sender_gaps     <= 1'b0;
            receiver_stalls <= 1'b0;
         end else if (i % 60 == 0) begin
            // some windows run at full rate on one or both sides
            sender_gaps     <= ((i / 60) % 3) != 2;
            receiver_stalls <= ((i / 60) % 4) != 3;
         end
         send_random_request();
      end
      drain_responses();
      repeat (10) @(posedge clock);

      if (board.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
